/* sv/sacache_pkg.sv */
// Shared types and constants for the set-associative cache timing model
`default_nettype none
package sacache_pkg;
	localparam int unsigned WORD_WRITE = 100;
	localparam int unsigned XFER_UNIT  = 100;
	localparam int unsigned OB_MAX     = 12;
	localparam int unsigned COST_W     = 19;
	localparam int unsigned XFER_W     = 17;

	typedef enum logic [2:0] {
		REG_INDEX_BITS     = 3'd0,
		REG_OFFSET_BITS    = 3'd1,
		REG_WAYS_USED      = 3'd2,
		REG_REPLACE_FIFO   = 3'd3,
		REG_WRITE_BACK     = 3'd4,
		REG_WRITE_ALLOCATE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        valid;
		logic        dirty;
		logic [31:0] addr;
		logic [31:0] load_stamp;
		logic [31:0] access_stamp;
	} line_t;

	// block transfer cost: (block bytes / 4) words at XFER_UNIT (100) each
	function automatic logic [XFER_W-1:0] xfer_cost(input logic [3:0] ob);
		logic [12:0] blk;
		blk = 13'd1 << ob;
		return XFER_W'(32'(blk >> 2) * XFER_UNIT);
	endfunction
endpackage
`default_nettype wire

/* sv/set_assoc_cache_timing_model.sv */
// Top level: set-associative cache timing model with a sequenced way scan
//
// channel   direction  transaction when          payload
// cfg       in         cfg_we high               cfg_index, cfg_data
// access    in         start high, busy low      mode, address
// result    out        done high (one cycle)     hit, allocated, evicted, wrote_back,
//                                                access_cost, total_cycles
//
// An access walks a read state and a check state for each of the W ways
// scanned (stops at the hit), then a cost and an update state; one way is read at a time.
// After reset the line store is swept clear, all MAX_SETS*MAX_WAYS lines
// (16384 by default), busy high meanwhile; config writes are taken always.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none
module set_assoc_cache_timing_model #(
	parameter int unsigned MAX_SETS = 1024,
	parameter int unsigned MAX_WAYS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [31:0] address,
	output logic             done,
	output logic             hit,
	output logic             allocated,
	output logic             evicted,
	output logic             wrote_back,
	output logic [17:0]      access_cost,
	output logic [47:0]      total_cycles
);
	import sacache_pkg::*;

	localparam int unsigned LINES  = MAX_SETS * MAX_WAYS;
	localparam int unsigned LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int unsigned MIB    = $clog2(MAX_SETS + 1) - 1;
	localparam int unsigned WI_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned WC_W   = $clog2(MAX_WAYS + 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK, ST_COST, ST_UPDATE
	} state_t;

	state_t state_q;

	logic [3:0] index_bits_q, offset_bits_q;
	logic [4:0] ways_used_q;
	logic       replace_fifo_q, write_back_q, write_allocate_q;

	line_t mem [LINES];
	line_t rdata_q;
	logic [LINE_W-1:0] raddr, waddr, clr_q;
	line_t wdata;
	logic  we;

	logic              mode_q;
	logic [31:0]       addr_q, tag_q;
	logic [4:0]        shift_q;
	logic [3:0]        ob_q;
	logic [LINE_W-1:0] base_q;
	logic [WC_W-1:0]   ways_q;
	logic [WI_W-1:0]   w_q, free_way_q, vic_way_q, hit_way_q;
	logic              hit_q, free_q, vic_dirty_q;
	logic [31:0]       min_q;
	line_t             hit_line_q, vic_line_q;
	logic              alloc_q, evict_q, wb_q;
	logic [COST_W-1:0] pre_q, cost_q;
	logic [47:0]       total_q;

	// combinational per-state values
	logic [4:0]        ib_eff;
	logic [3:0]        ob_eff;
	logic [WC_W-1:0]   ways_eff;
	logic [31:0]       set_full;
	logic [31:0]       cur_stamp;
	logic              last_way;
	logic              is_alloc, is_evict, is_wb;
	logic [XFER_W-1:0] xfer;
	logic [COST_W-1:0] wbx, pre_c, cost_c;
	logic [47:0]       stamp_total, new_total;
	logic [WI_W-1:0]   upd_way;

	always_comb begin
		ib_eff = (32'(index_bits_q) > MIB) ? 5'(MIB) : {1'b0, index_bits_q};
		ob_eff = (32'(offset_bits_q) > OB_MAX) ? 4'(OB_MAX) : offset_bits_q;
		if (ways_used_q == 5'd0) begin
			ways_eff = WC_W'(1);
		end else if (32'(ways_used_q) > MAX_WAYS) begin
			ways_eff = WC_W'(MAX_WAYS);
		end else begin
			ways_eff = WC_W'(ways_used_q);
		end
		set_full  = (address >> ob_eff) & ((32'd1 << ib_eff) - 32'd1);
		cur_stamp = replace_fifo_q ? rdata_q.load_stamp : rdata_q.access_stamp;
		last_way  = (32'(w_q) + 32'd1) >= 32'(ways_q);

		is_alloc = !hit_q && (!mode_q || write_allocate_q);
		is_evict = is_alloc && !free_q;
		is_wb    = is_evict && write_back_q && vic_dirty_q;
		xfer     = xfer_cost(ob_q);
		wbx      = is_wb ? COST_W'(xfer) : '0;
		pre_c    = COST_W'(1);
		cost_c   = COST_W'(1);
		if (hit_q) begin
			if (mode_q) begin
				cost_c = write_back_q ? COST_W'(2) : COST_W'(WORD_WRITE + 2);
			end
			pre_c = cost_c;
		end else if (is_alloc) begin
			if (!mode_q) begin
				pre_c  = COST_W'(1) + COST_W'(xfer) + wbx;
				cost_c = pre_c;
			end else begin
				pre_c  = COST_W'(1) + wbx;
				cost_c = pre_c + COST_W'(1) + COST_W'(xfer)
					+ (write_back_q ? COST_W'(0) : COST_W'(WORD_WRITE));
			end
		end else begin
			cost_c = COST_W'(WORD_WRITE + 1);
		end

		stamp_total = total_q + 48'(pre_q);
		new_total   = total_q + 48'(cost_q);

		raddr   = base_q + LINE_W'(w_q);
		upd_way = hit_q ? hit_way_q : (free_q ? free_way_q : vic_way_q);
		waddr   = base_q + LINE_W'(upd_way);
		we      = 1'b0;
		wdata   = '0;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (state_q == ST_UPDATE) begin
			if (hit_q) begin
				we                 = 1'b1;
				wdata              = hit_line_q;
				wdata.dirty        = hit_line_q.dirty | (mode_q & write_back_q);
				wdata.access_stamp = stamp_total[31:0];
			end else if (alloc_q) begin
				we                 = 1'b1;
				wdata.valid        = 1'b1;
				wdata.dirty        = mode_q & write_back_q;
				wdata.addr         = addr_q;
				wdata.load_stamp   = stamp_total[31:0];
				wdata.access_stamp = stamp_total[31:0];
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q     <= 4'd8;
			offset_bits_q    <= 4'd4;
			ways_used_q      <= 5'd1;
			replace_fifo_q   <= 1'b0;
			write_back_q     <= 1'b1;
			write_allocate_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INDEX_BITS:     index_bits_q     <= cfg_data[3:0];
				REG_OFFSET_BITS:    offset_bits_q    <= cfg_data[3:0];
				REG_WAYS_USED:      ways_used_q      <= cfg_data;
				REG_REPLACE_FIFO:   replace_fifo_q   <= cfg_data[0];
				REG_WRITE_BACK:     write_back_q     <= cfg_data[0];
				REG_WRITE_ALLOCATE: write_allocate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			total_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LINE_W'(1);
					if (clr_q == LINE_W'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						addr_q  <= address;
						ob_q    <= ob_eff;
						shift_q <= 5'(ob_eff) + ib_eff;
						tag_q   <= address >> (5'(ob_eff) + ib_eff);
						base_q  <= LINE_W'(set_full * 32'(MAX_WAYS));
						ways_q  <= ways_eff;
						w_q     <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (rdata_q.valid && ((rdata_q.addr >> shift_q) == tag_q)) begin
						hit_q      <= 1'b1;
						hit_way_q  <= w_q;
						hit_line_q <= rdata_q;
						state_q    <= ST_COST;
					end else begin
						if (!rdata_q.valid && !free_q) begin
							free_q     <= 1'b1;
							free_way_q <= w_q;
						end
						// oldest stamp wins, lowest way on a tie
						if (w_q == '0 || cur_stamp < min_q) begin
							min_q       <= cur_stamp;
							vic_way_q   <= w_q;
							vic_dirty_q <= rdata_q.dirty;
							vic_line_q  <= rdata_q;
						end
						if (last_way) begin
							state_q <= ST_COST;
						end else begin
							w_q     <= w_q + WI_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_COST: begin
					pre_q   <= pre_c;
					cost_q  <= cost_c;
					alloc_q <= is_alloc;
					evict_q <= is_evict && vic_line_q.valid;
					wb_q    <= is_wb;
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					total_q      <= new_total;
					done         <= 1'b1;
					hit          <= hit_q;
					allocated    <= alloc_q;
					evicted      <= evict_q;
					wrote_back   <= wb_q;
					access_cost  <= cost_q[17:0];
					total_cycles <= new_total;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire
